FILE: src/agl_pkg.sv
// ----------------------------------------------------------------------------
// agl_pkg
// Shared types and constants of the antialiased gradient line rasterizer.
// ----------------------------------------------------------------------------
package agl_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SLOPE,
        ST_CH_INIT,
        ST_CH_DIV,
        ST_CH_SCALE,
        ST_EMIT0,
        ST_EMIT1
    } t_state;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic load;      // latch a start item
        logic div_start; // begin a division
        logic div_slope; // division is the slope (else a color channel)
        logic ch_scale;  // scale quotient by coverage, store channel
        logic ch_next;   // advance channel/pixel index
        logic advance;   // step to the next column
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic ch_done;   // index is at the last of the six channel values
        logic fin;
    } t_status;

endpackage

FILE: src/agl_div.sv
// ----------------------------------------------------------------------------
// agl_div
// Restoring divider for unsigned magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module agl_div #(
    parameter int W = 48
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_busy,
    output logic [W-1:0] o_quot
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_q, n_q;
    logic [W:0]    r_rem, n_rem;
    logic [W-1:0]  r_den;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [W:0]    w_trial;

    assign w_trial = {r_rem[W-1:0], r_q[W-1]} - {1'b0, r_den};

    always_comb begin
        n_q   = r_q;
        n_rem = r_rem;
        n_cnt = r_cnt;
        if (i_start) begin
            n_q   = i_num;
            n_rem = '0;
            n_cnt = CW'(W);
        end else if (r_cnt != '0) begin
            if (!w_trial[W]) begin
                n_rem = w_trial;
                n_q   = {r_q[W-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[W-1:0], r_q[W-1]};
                n_q   = {r_q[W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_q;
endmodule

FILE: src/agl_datapath.sv
// ----------------------------------------------------------------------------
// agl_datapath
// Line setup, column state, shared divider and pixel shading.
// ----------------------------------------------------------------------------
module agl_datapath #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  agl_pkg::t_cmd              i_cmd,
    output agl_pkg::t_status           o_status,
    input  logic signed [COORD_BITS-1:0] i_xs,
    input  logic signed [COORD_BITS-1:0] i_ys,
    input  logic signed [COORD_BITS-1:0] i_xe,
    input  logic signed [COORD_BITS-1:0] i_ye,
    input  logic [23:0]                i_cs,
    input  logic [23:0]                i_ce,
    input  logic                       i_pix,   // 0 lower pixel, 1 upper
    output logic [COORD_BITS:0]        o_px,
    output logic [COORD_BITS:0]        o_py,
    output logic [23:0]                o_color
);
    import agl_pkg::*;

    localparam int CB = COORD_BITS + 1;          // differences
    localparam int AW = CB + FRAC_BITS + 2;      // accumulator
    localparam int DW = CB + FRAC_BITS + 1;      // divider width
    localparam int MW = CB + 9;                  // color numerator

    logic              r_steep;
    logic signed [CB-1:0] r_col, r_first, r_final;
    logic signed [AW-1:0] r_acc, r_slope;
    logic signed [CB-1:0] r_dy;
    logic [23:0]       r_c0, r_c1;
    logic [7:0]        r_val [6];
    logic [2:0]        r_idx;

    // setup
    logic signed [CB-1:0] w_dxa, w_dya, w_ax, w_ay, w_bx, w_by;
    logic signed [CB-1:0] w_sx, w_sy, w_ex, w_ey;
    logic w_steep, w_rev;
    always_comb begin
        w_dxa = CB'(i_xe) - CB'(i_xs);
        w_dya = CB'(i_ye) - CB'(i_ys);
        if (w_dxa < 0) w_dxa = -w_dxa;
        if (w_dya < 0) w_dya = -w_dya;
        w_steep = w_dya > w_dxa;
        w_ax = w_steep ? CB'(i_ys) : CB'(i_xs);
        w_ay = w_steep ? CB'(i_xs) : CB'(i_ys);
        w_bx = w_steep ? CB'(i_ye) : CB'(i_xe);
        w_by = w_steep ? CB'(i_xe) : CB'(i_ye);
        w_rev = w_ax > w_bx;
        w_sx = w_rev ? w_bx : w_ax;
        w_sy = w_rev ? w_by : w_ay;
        w_ex = w_rev ? w_ax : w_bx;
        w_ey = w_rev ? w_ay : w_by;
    end

    // column values
    logic [CB-1:0] w_num, w_den;
    logic [FRAC_BITS-1:0] w_f;
    logic signed [CB-1:0] w_row;
    logic [1:0] w_ch;
    logic [7:0] w_a, w_b;
    logic signed [MW-1:0] w_cnum;
    assign w_num = r_col - r_first;
    assign w_den = r_final - r_first;
    assign w_f   = r_acc[FRAC_BITS-1:0];
    assign w_row = CB'(r_acc >>> FRAC_BITS);
    assign w_ch  = (r_idx >= 3'd3) ? 2'(r_idx - 3'd3) : r_idx[1:0];
    always_comb begin
        case (w_ch)
            2'd0:    begin w_a = r_c0[23:16]; w_b = r_c1[23:16]; end
            2'd1:    begin w_a = r_c0[15:8];  w_b = r_c1[15:8];  end
            default: begin w_a = r_c0[7:0];   w_b = r_c1[7:0];   end
        endcase
        w_cnum = $signed({1'b0, w_a}) * $signed({1'b0, w_den})
               + ($signed({1'b0, w_b}) - $signed({1'b0, w_a})) * $signed({1'b0, w_num});
    end

    // divider: slope |dy|<<F / dx, or color numerator / den (numerator >= 0)
    logic [DW-1:0] w_dnum, w_dden, w_quot;
    logic          w_busy;
    logic [CB-1:0] w_dyabs;
    assign w_dyabs = (r_dy < 0) ? CB'(-r_dy) : CB'(r_dy);
    always_comb begin
        if (i_cmd.div_slope) begin
            w_dnum = DW'({w_dyabs, {FRAC_BITS{1'b0}}});
            w_dden = DW'(w_den);
        end else begin
            w_dnum = DW'(unsigned'(w_cnum));
            w_dden = DW'(w_den);
        end
    end
    agl_div #(.W(DW)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  (w_dnum),
        .i_den  (w_dden),
        .o_busy (w_busy),
        .o_quot (w_quot)
    );

    // coverage scaling
    logic [7:0]           w_v;
    logic [FRAC_BITS:0]   w_cov;
    logic [FRAC_BITS+8:0] w_prod;
    assign w_v    = (w_den == '0) ? w_a : w_quot[7:0];
    assign w_cov  = (r_idx >= 3'd3) ? {1'b0, w_f}
                                    : ((FRAC_BITS+1)'(1) << FRAC_BITS) - {1'b0, w_f};
    assign w_prod = w_v * w_cov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.load || i_cmd.advance) begin
            r_idx <= '0;
        end else if (i_cmd.ch_next) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.load) begin
            r_steep <= w_steep;
            r_first <= w_sx;
            r_final <= w_ex;
            r_col   <= w_sx;
            r_dy    <= w_ey - w_sy;
            r_acc   <= AW'(w_sy) <<< FRAC_BITS;
            r_c0    <= w_rev ? i_ce : i_cs;
            r_c1    <= w_rev ? i_cs : i_ce;
        end
        if (i_cmd.div_slope && !i_cmd.div_start && !w_busy) begin
            if (w_den == '0)
                r_slope <= AW'(1) <<< FRAC_BITS;
            else if (r_dy < 0)
                r_slope <= -AW'(w_quot);
            else
                r_slope <= AW'(w_quot);
        end
        if (i_cmd.ch_scale) begin
            r_val[r_idx] <= w_prod[FRAC_BITS+7:FRAC_BITS];
        end
        if (i_cmd.advance) begin
            r_col <= r_col + 1'b1;
            r_acc <= r_acc + r_slope;
        end
    end

    logic signed [CB-1:0] w_prow;
    assign w_prow  = i_pix ? w_row + 1'b1 : w_row;
    assign o_px    = r_steep ? w_prow : r_col;
    assign o_py    = r_steep ? r_col : w_prow;
    assign o_color = i_pix ? {r_val[3], r_val[4], r_val[5]}
                           : {r_val[0], r_val[1], r_val[2]};

    assign o_status.div_busy = w_busy;
    assign o_status.ch_done  = (r_idx == 3'd5);
    assign o_status.fin      = (r_col >= r_final);
endmodule

FILE: src/agl_ctrl.sv
// ----------------------------------------------------------------------------
// agl_ctrl
// Sequencer: setup, per channel division and scaling, two pixel outputs.
// ----------------------------------------------------------------------------
module agl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_op,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_pix,
    output logic              o_last,
    output agl_pkg::t_cmd     o_cmd,
    input  agl_pkg::t_status  i_status
);
    import agl_pkg::*;

    t_state r_state, n_state;
    logic   r_active, n_active;
    logic   w_acc_in, w_acc_out;

    assign w_acc_in  = i_in_valid && o_in_ready;
    assign w_acc_out = o_out_valid && i_out_ready;

    always_comb begin
        n_state  = r_state;
        n_active = r_active;
        case (r_state)
            ST_IDLE: begin
                if (w_acc_in) begin
                    if (i_in_op == OP_START) begin
                        n_state  = ST_SLOPE;
                        n_active = 1'b1;
                    end else if (r_active) begin
                        n_state = ST_CH_INIT;
                    end
                end
            end
            ST_SLOPE:    if (!i_status.div_busy && !o_cmd.div_start) n_state = ST_IDLE;
            ST_CH_INIT:  n_state = ST_CH_DIV;
            ST_CH_DIV:   if (!i_status.div_busy) n_state = ST_CH_SCALE;
            ST_CH_SCALE: n_state = i_status.ch_done ? ST_EMIT0 : ST_CH_INIT;
            ST_EMIT0:    if (w_acc_out) n_state = ST_EMIT1;
            ST_EMIT1: begin
                if (w_acc_out) begin
                    n_state = ST_IDLE;
                    if (i_status.fin) n_active = 1'b0;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    logic r_slope_go;
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_pix       = 1'b0;
        o_last      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid && (i_in_op == OP_START);
            end
            ST_SLOPE: begin
                o_cmd.div_slope = 1'b1;
                o_cmd.div_start = r_slope_go;
            end
            ST_CH_INIT:  o_cmd.div_start = 1'b1;
            ST_CH_SCALE: begin
                o_cmd.ch_scale = 1'b1;
                o_cmd.ch_next  = !i_status.ch_done;
            end
            ST_EMIT0:    o_out_valid = 1'b1;
            ST_EMIT1: begin
                o_out_valid   = 1'b1;
                o_pix         = 1'b1;
                o_last        = i_status.fin;
                o_cmd.advance = w_acc_out && !i_status.fin;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_active   <= 1'b0;
            r_slope_go <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_active   <= n_active;
            r_slope_go <= (r_state == ST_IDLE) && (n_state == ST_SLOPE);
        end
    end
endmodule

FILE: src/antialiased_gradient_line.sv
// ----------------------------------------------------------------------------
// antialiased_gradient_line
// Wu antialiased line rasterizer with a per channel RGB color gradient.
// ----------------------------------------------------------------------------
//  channel | dir | contents
//  s_axis  | in  | tuser = opcode; tdata = endpoints and colors
//  m_axis  | out | tdata = pixel x, y, color; tlast = last pixel of the line
//
// For a start item the slope comes from the shared restoring divider (DW =
// COORD_BITS+FRAC_BITS+2 quotient bits); the block is busy for the division.
// A step item, only while a line is active, runs six color divisions in the
// same divider, then two output transactions.
// Reset is synchronous, active low; it drops any line in progress.
// A stalled m_axis holds the pixel and no new input is taken meanwhile.
module antialiased_gradient_line #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // tdata: x_start, y_start, x_end, y_end, color_start[23:0], color_end[23:0]
    input  logic [((4*COORD_BITS+48+7)/8)*8-1:0] s_axis_tdata,
    // tuser: opcode
    input  logic                    s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // tdata: pixel_x, pixel_y, pixel_color[23:0]
    output logic [((2*COORD_BITS+26+7)/8)*8-1:0] m_axis_tdata,
    output logic                    m_axis_tlast
);
    import agl_pkg::*;

    localparam int C = COORD_BITS;
    localparam int OW = ((2*COORD_BITS+26+7)/8)*8;

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_pix;
    logic [C:0] w_px, w_py;
    logic [23:0] w_color;

    agl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_op    (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .o_pix      (w_pix),
        .o_last     (m_axis_tlast),
        .o_cmd      (w_cmd),
        .i_status   (w_status)
    );

    agl_datapath #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_status(w_status),
        .i_xs    (s_axis_tdata[C-1:0]),
        .i_ys    (s_axis_tdata[2*C-1:C]),
        .i_xe    (s_axis_tdata[3*C-1:2*C]),
        .i_ye    (s_axis_tdata[4*C-1:3*C]),
        .i_cs    (s_axis_tdata[4*C+23:4*C]),
        .i_ce    (s_axis_tdata[4*C+47:4*C+24]),
        .i_pix   (w_pix),
        .o_px    (w_px),
        .o_py    (w_py),
        .o_color (w_color)
    );

    assign m_axis_tdata = OW'({w_color, w_py, w_px});
endmodule

FILE: tb/antialiased_gradient_line_test.sv
// ----------------------------------------------------------------------------
// antialiased_gradient_line_test
// Self-checking bench for the Wu gradient line rasterizer: directed lines
// (extremes, steep, reversed, degenerate, no-line steps) then random lines,
// with random gaps on both streams and a pixel predictor that runs in step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module antialiased_gradient_line_test;
    import agl_pkg::*;

    localparam int  ONE_FIX   = 1 << 16;
    localparam int  WD_LIMIT  = 6000;   // idle cycles with no transaction
    localparam int  N_RANDOM  = 1200;

    typedef struct {
        logic               op;
        logic signed [11:0] xs, ys, xe, ye;
        logic [23:0]        cs, ce;
    } t_cmd_item;

    typedef struct packed {
        logic [12:0] px, py;
        logic [23:0] color;
        logic        last;
    } t_pixel;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;  // xs, ys, xe, ye, color_start, color_end
    logic        s_axis_tuser = 1'b0; // opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;       // pixel_x, pixel_y, pixel_color, pad
    logic        m_axis_tlast;

    antialiased_gradient_line dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_cmd_item pending_cmds[$];
    t_pixel    expected_pixels[$];
    bit        calm = 0;          // stretch with no idling on either side
    int        items_queued = 0;
    int        mismatches = 0;
    int        lines_started = 0, columns_drawn = 0, pixels_seen = 0;

    // predictor copy of the line state
    bit          ln_active, ln_steep;
    longint      ln_col, ln_first, ln_final, ln_acc, ln_slope;
    logic [23:0] ln_c_left, ln_c_right;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [23:0] shade_color(longint num, longint den, longint cov);
        logic [23:0] out;
        longint a, b, v;
        out = '0;
        for (int ch = 0; ch < 3; ch++) begin
            a = ln_c_left[ch*8 +: 8];
            b = ln_c_right[ch*8 +: 8];
            v = a;
            if (den != 0) v = (a * den + (b - a) * num) / den;
            v = (v * cov) / ONE_FIX;
            out[ch*8 +: 8] = v[7:0];
        end
        return out;
    endfunction

    function automatic t_pixel make_pixel(longint col, longint row, logic [23:0] c,
                                          logic lst);
        t_pixel p;
        p.px = ln_steep ? row[12:0] : col[12:0];
        p.py = ln_steep ? col[12:0] : row[12:0];
        p.color = c;
        p.last = lst;
        return p;
    endfunction

    // advance the predicted line state by one accepted transaction
    task automatic rasterize(input t_cmd_item it);
        longint sx, sy, ex, ey, t, dx, dy, f, row, num, den;
        bit     fin;
        if (it.op == OP_START) begin
            sx = it.xs; sy = it.ys; ex = it.xe; ey = it.ye;
            dx = ex - sx; dy = ey - sy;
            ln_steep = (dy < 0 ? -dy : dy) > (dx < 0 ? -dx : dx);
            if (ln_steep) begin
                t = sx; sx = sy; sy = t;
                t = ex; ex = ey; ey = t;
            end
            if (sx > ex) begin
                t = sx; sx = ex; ex = t;
                t = sy; sy = ey; ey = t;
                ln_c_left = it.ce; ln_c_right = it.cs;
            end else begin
                ln_c_left = it.cs; ln_c_right = it.ce;
            end
            dx = ex - sx; dy = ey - sy;
            ln_slope = (dx == 0) ? ONE_FIX : (dy * ONE_FIX) / dx;
            ln_acc = sy * ONE_FIX;
            ln_first = sx; ln_final = ex; ln_col = sx;
            ln_active = 1;
            lines_started++;
        end else if (ln_active) begin
            f = ln_acc & (ONE_FIX - 1);
            row = ln_acc >>> 16;
            num = ln_col - ln_first;
            den = ln_final - ln_first;
            fin = ln_col >= ln_final;
            expected_pixels.push_back(make_pixel(ln_col, row,
                shade_color(num, den, ONE_FIX - f), 1'b0));
            expected_pixels.push_back(make_pixel(ln_col, row + 1,
                shade_color(num, den, f), fin));
            columns_drawn++;
            if (fin) ln_active = 0;
            else begin
                ln_col++;
                ln_acc += ln_slope;
            end
        end
    endtask

    task automatic queue_line(int xs, int ys, int xe, int ye, int cs, int ce, int steps);
        t_cmd_item it;
        it.op = OP_START;
        it.xs = 12'(xs); it.ys = 12'(ys); it.xe = 12'(xe); it.ye = 12'(ye);
        it.cs = 24'(cs); it.ce = 24'(ce);
        pending_cmds.push_back(it);
        items_queued++;
        it.op = OP_STEP;
        for (int k = 0; k < steps; k++) begin
            // step items carry junk in the unused fields
            it.xs = 12'($urandom); it.ys = 12'($urandom);
            it.xe = 12'($urandom); it.ye = 12'($urandom);
            it.cs = 24'($urandom); it.ce = 24'($urandom);
            pending_cmds.push_back(it);
            items_queued++;
        end
    endtask

    function automatic int near_coord(int base, int span);
        int d, v;
        d = $urandom_range(0, span);
        if ($urandom_range(0, 1)) d = -d;
        v = base + d;
        if (v > 2047 || v < -2048) v = base - d;
        return v;
    endfunction

    function automatic int rand_coord();
        logic signed [11:0] v;
        v = 12'($urandom);
        return v;
    endfunction

    // driver: one transaction per handshake, random gaps between them
    int  in_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                rasterize('{s_axis_tuser, s_axis_tdata[11:0], s_axis_tdata[23:12],
                            s_axis_tdata[35:24], s_axis_tdata[47:36],
                            s_axis_tdata[71:48], s_axis_tdata[95:72]});
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (in_gap > 0 || pending_cmds.size() == 0) begin
                    if (in_gap > 0) in_gap--;
                    s_axis_tvalid <= 1'b0;
                end else begin
                    t_cmd_item it;
                    it = pending_cmds.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= it.op;
                    s_axis_tdata  <= {it.ce, it.cs, it.ye, it.xe, it.ys, it.xs};
                    in_gap = pick_gap();
                end
            end
        end
    end

    // monitor: random backpressure, compare against the oldest prediction
    int out_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                t_pixel got, want;
                got.px = m_axis_tdata[12:0];
                got.py = m_axis_tdata[25:13];
                got.color = m_axis_tdata[49:26];
                got.last = m_axis_tlast;
                pixels_seen++;
                if (expected_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected pixel x=%0d y=%0d color=%06h last=%0b",
                                 $signed(got.px), $signed(got.py), got.color, got.last);
                end else begin
                    want = expected_pixels.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("pixel %0d: exp x=%0d y=%0d c=%06h l=%0b got x=%0d y=%0d c=%06h l=%0b",
                                     pixels_seen, $signed(want.px), $signed(want.py),
                                     want.color, want.last, $signed(got.px),
                                     $signed(got.py), got.color, got.last);
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) out_gap = pick_gap();
            end
        end
    end

    // watchdog: too long without any transaction means a hang
    int quiet = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WD_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WD_LIMIT);
            $display("antialiased_gradient_line_test: errors");
            $finish;
        end
    end

    initial begin
        int kind, x0, y0, x1, y1, major, ax, ay;
        // directed: no-line step, extremes, steep, reversed, degenerate
        pending_cmds.push_back('{OP_STEP, 12'h7ff, 12'h800, 12'h7ff, 12'h800,
                                 24'hffffff, 24'h0});
        items_queued++;
        queue_line(-2048, -2048, 2047, 2047, 24'h000000, 24'hffffff, 3);
        queue_line(2047, 2047, -2048, -2048, 24'hffffff, 24'h000000, 2);
        queue_line(5, 5, 5, 5, 24'h12ab34, 24'hffffff, 2);      // degenerate, extra step
        queue_line(10, 3, 4, 1, 24'hff0000, 24'h0000ff, 7);     // reversed shallow
        queue_line(0, 0, 2, 6, 24'h00ff00, 24'hff00ff, 7);      // steep
        queue_line(-3, 4, -1, -2, 24'hffffff, 24'h808080, 7);   // steep reversed
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (items_queued < N_RANDOM) begin
            if (items_queued % 300 < 40) calm = 1;
            else calm = 0;
            kind = $urandom_range(0, 99);
            x0 = rand_coord(); y0 = rand_coord();
            if (kind < 85) begin
                x1 = near_coord(x0, 12); y1 = near_coord(y0, 12);
                ax = x1 > x0 ? x1 - x0 : x0 - x1;
                ay = y1 > y0 ? y1 - y0 : y0 - y1;
                major = ax > ay ? ax : ay;
                queue_line(x0, y0, x1, y1, $urandom, $urandom,
                           major + 1 + ($urandom_range(0, 9) == 0));
            end else if (kind < 95) begin
                // long line dropped after a few columns by the next start
                queue_line(x0, y0, rand_coord(), rand_coord(), $urandom, $urandom,
                           $urandom_range(0, 4));
            end else begin
                queue_line(x0, y0, x0, y0, $urandom, $urandom, $urandom_range(1, 3));
            end
            while (pending_cmds.size() > 40) @(posedge i_clk);
        end
        wait (pending_cmds.size() == 0);
        @(posedge i_clk);
        while (s_axis_tvalid) @(posedge i_clk);
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        $display("covered %0d lines, %0d columns, %0d pixels checked",
                 lines_started, columns_drawn, pixels_seen);
        $display("mismatches: %0d, predictions left over: %0d",
                 mismatches, expected_pixels.size());
        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("antialiased_gradient_line_test: clean");
        else
            $display("antialiased_gradient_line_test: errors");
        $finish;
    end

endmodule
